[sv/vfpa_pkg.sv]
// Package for the vortex flow particle advection block.
// Holds fixed-point constants, register indexes and the CORDIC angle table.
// Depends on nothing.
`default_nettype none
package vfpa_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int CORDIC_STAGES_DEF = 24;

    localparam int CORD_W = 34;
    localparam int Z_W = 64;
    localparam int F_W = 37;

    localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
    localparam logic [38:0] PI_Q37 = 39'(PI_Q61 >> 24);
    localparam logic signed [CORD_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [24:0] HALF_Q24 = 25'h0800000;

    localparam logic [31:0] SIM_TIME_RST = 32'd0;
    localparam logic [30:0] TIME_STEP_RST = 31'd16777;
    localparam logic [30:0] INV_PERIOD_RST = 31'd2097152;

    typedef enum logic [1:0] {
        REG_SIM_TIME   = 2'd0,
        REG_TIME_STEP  = 2'd1,
        REG_INV_PERIOD = 2'd2
    } cfg_reg_t;

    function automatic logic signed [Z_W-1:0] atan_q61(input int idx);
        logic [63:0] acc;
        logic [63:0] term;
        int e;
        int k;
        acc = 64'd0;
        if (idx == 0)
        begin
            acc = PI_Q61 >> 2;
        end
        else
        begin
            for (k = 0; k < 64; k++)
            begin
                e = 61 - idx * (2 * k + 1);
                if (e >= 0)
                begin
                    term = (64'd1 << e) / 64'(2 * k + 1);
                    if (k % 2 == 1)
                        acc = acc - term;
                    else
                        acc = acc + term;
                end
            end
        end
        return signed'(acc);
    endfunction

endpackage
`default_nettype wire

[sv/vortex_flow_particle_advect.sv]
// Top level of the vortex flow particle advection block: CORDIC pipeline,
// product chain and saturation. Depends on vfpa_pkg.
//
// One particle transaction is accepted every cycle unless the pipeline halts;
// the pipeline consists of an input stage, an angle reduction stage and the
// pipelined CORDIC with one register stage per rotation, followed by a sign stage,
// three multiplier stages and a saturation stage. The whole pipeline halts
// only while a finished result waits on out_stall. Configuration writes are
// accepted at any time with cfg_ready held high and must be made while no
// particle is in flight.
`default_nettype none
module vortex_flow_particle_advect
    import vfpa_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [COORD_WIDTH-1:0] x_pos,
    input  wire logic signed [COORD_WIDTH-1:0] y_pos,
    input  wire logic                          last_particle,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0]      new_x,
    output logic signed [COORD_WIDTH-1:0]      new_y,
    output logic                               last_out,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int NS = CORDIC_STAGES;
    localparam int D_W = F_W + CORD_W - 30;
    localparam int SUM_W = ((CW > D_W) ? CW : D_W) + 2;

    logic [31:0] sim_time_reg;
    logic [30:0] time_step_reg;
    logic [30:0] inv_period_reg;

    logic adv;

    logic v1_reg;
    logic signed [CW-1:0] x1_reg, y1_reg;
    logic l1_reg;
    logic [24:0] prod1_reg;

    logic [NS:0] cv_reg;
    logic signed [CW-1:0] cx_x_reg [NS+1];
    logic signed [CW-1:0] cy_y_reg [NS+1];
    logic [NS:0] cl_reg;
    logic signed [CORD_W-1:0] cc_reg [NS+1][3];
    logic signed [CORD_W-1:0] cs_reg [NS+1][3];
    logic signed [Z_W-1:0] cz_reg [NS+1][3];
    logic [2:0] cn_reg [NS+1];

    logic [24:0] phase [3];
    logic [24:0] w [3];
    logic signed [24:0] r [3];
    logic signed [Z_W-1:0] z0_next [3];

    logic v3_reg, l3_reg;
    logic signed [CW-1:0] x3_reg, y3_reg;
    logic signed [CORD_W-1:0] sx3_reg, cx3_reg, sy3_reg, cy3_reg, tc3_reg;

    logic v4_reg, l4_reg;
    logic signed [CW-1:0] x4_reg, y4_reg;
    logic signed [CORD_W-1:0] sxsx4_reg, cysy4_reg, cxsx4_reg, sysy4_reg;
    logic signed [F_W-1:0] f4_reg;
    logic signed [2*CORD_W-1:0] sxsx_next, cysy_next, cxsx_next, sysy_next;
    logic signed [65:0] f_next;

    logic v5_reg, l5_reg;
    logic signed [CW-1:0] x5_reg, y5_reg;
    logic signed [F_W-1:0] f5_reg;
    logic signed [2*CORD_W-1:0] gp5_reg, hp5_reg;

    logic v6_reg, l6_reg;
    logic signed [CW-1:0] x6_reg, y6_reg;
    logic signed [F_W+CORD_W-1:0] dxp6_reg, dyp6_reg;
    logic signed [CORD_W-1:0] gx_next, hy_next;

    logic v7_reg, l7_reg;
    logic signed [CW-1:0] nx7_reg, ny7_reg;
    logic signed [D_W-1:0] dx_next, dy_next;
    logic signed [SUM_W-1:0] sumx, sumy;
    logic signed [CW-1:0] nx_next, ny_next;

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [SUM_W-1:0] s);
        logic signed [CW-1:0] res;
        if (s[SUM_W-1:CW-1] == {(SUM_W-CW+1){1'b0}} ||
            s[SUM_W-1:CW-1] == {(SUM_W-CW+1){1'b1}})
            res = s[CW-1:0];
        else if (s[SUM_W-1])
            res = {1'b1, {(CW-1){1'b0}}};
        else
            res = {1'b0, {(CW-1){1'b1}}};
        return res;
    endfunction

    assign cfg_ready = 1'b1;
    assign adv = !(v7_reg && out_stall);
    assign in_stall = !adv;
    assign out_valid = v7_reg;
    assign new_x = nx7_reg;
    assign new_y = ny7_reg;
    assign last_out = l7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sim_time_reg <= SIM_TIME_RST;
            time_step_reg <= TIME_STEP_RST;
            inv_period_reg <= INV_PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SIM_TIME:   sim_time_reg <= cfg_data;
                REG_TIME_STEP:  time_step_reg <= cfg_data[30:0];
                REG_INV_PERIOD: inv_period_reg <= cfg_data[30:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            cv_reg <= '0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            cv_reg <= {cv_reg[NS-1:0], v1_reg};
            v3_reg <= cv_reg[NS];
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_comb
    begin
        phase[0] = 25'(Z_W'(x1_reg));
        phase[1] = 25'(Z_W'(y1_reg));
        phase[2] = prod1_reg;
        for (int l = 0; l < 3; l++)
        begin
            w[l] = phase[l] + HALF_Q24;
            r[l] = signed'({1'b0, w[l][23:0]}) - signed'(HALF_Q24);
            z0_next[l] = Z_W'(r[l]) * Z_W'(signed'({1'b0, PI_Q37}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg <= x_pos;
            y1_reg <= y_pos;
            l1_reg <= last_particle;
            prod1_reg <= 25'((64'(sim_time_reg) * 64'(inv_period_reg)) >> 16);

            cx_x_reg[0] <= x1_reg;
            cy_y_reg[0] <= y1_reg;
            cl_reg[0] <= l1_reg;
            for (int l = 0; l < 3; l++)
            begin
                cc_reg[0][l] <= GAIN_Q30;
                cs_reg[0][l] <= '0;
                cz_reg[0][l] <= z0_next[l];
                cn_reg[0][l] <= w[l][24];
            end

            for (int j = 0; j < NS; j++)
            begin
                cx_x_reg[j+1] <= cx_x_reg[j];
                cy_y_reg[j+1] <= cy_y_reg[j];
                cl_reg[j+1] <= cl_reg[j];
                cn_reg[j+1] <= cn_reg[j];
                for (int l = 0; l < 3; l++)
                begin
                    if (!cz_reg[j][l][Z_W-1])
                    begin
                        cc_reg[j+1][l] <= cc_reg[j][l] - (cs_reg[j][l] >>> j);
                        cs_reg[j+1][l] <= cs_reg[j][l] + (cc_reg[j][l] >>> j);
                        cz_reg[j+1][l] <= cz_reg[j][l] - atan_q61(j);
                    end
                    else
                    begin
                        cc_reg[j+1][l] <= cc_reg[j][l] + (cs_reg[j][l] >>> j);
                        cs_reg[j+1][l] <= cs_reg[j][l] - (cc_reg[j][l] >>> j);
                        cz_reg[j+1][l] <= cz_reg[j][l] + atan_q61(j);
                    end
                end
            end

            x3_reg <= cx_x_reg[NS];
            y3_reg <= cy_y_reg[NS];
            l3_reg <= cl_reg[NS];
            sx3_reg <= cn_reg[NS][0] ? -cs_reg[NS][0] : cs_reg[NS][0];
            cx3_reg <= cn_reg[NS][0] ? -cc_reg[NS][0] : cc_reg[NS][0];
            sy3_reg <= cn_reg[NS][1] ? -cs_reg[NS][1] : cs_reg[NS][1];
            cy3_reg <= cn_reg[NS][1] ? -cc_reg[NS][1] : cc_reg[NS][1];
            tc3_reg <= cn_reg[NS][2] ? -cc_reg[NS][2] : cc_reg[NS][2];

            x4_reg <= x3_reg;
            y4_reg <= y3_reg;
            l4_reg <= l3_reg;
            sxsx4_reg <= CORD_W'(sxsx_next >>> 30);
            cysy4_reg <= CORD_W'(cysy_next >>> 30);
            cxsx4_reg <= CORD_W'(cxsx_next >>> 30);
            sysy4_reg <= CORD_W'(sysy_next >>> 30);
            f4_reg <= F_W'(f_next >>> 29);

            x5_reg <= x4_reg;
            y5_reg <= y4_reg;
            l5_reg <= l4_reg;
            f5_reg <= f4_reg;
            gp5_reg <= sxsx4_reg * cysy4_reg;
            hp5_reg <= cxsx4_reg * sysy4_reg;

            x6_reg <= x5_reg;
            y6_reg <= y5_reg;
            l6_reg <= l5_reg;
            dxp6_reg <= (F_W+CORD_W)'(f5_reg) * (F_W+CORD_W)'(gx_next);
            dyp6_reg <= (F_W+CORD_W)'(f5_reg) * (F_W+CORD_W)'(hy_next);

            nx7_reg <= nx_next;
            ny7_reg <= ny_next;
            l7_reg <= l6_reg;
        end
    end

    always_comb
    begin
        sxsx_next = sx3_reg * sx3_reg;
        cysy_next = cy3_reg * sy3_reg;
        cxsx_next = cx3_reg * sx3_reg;
        sysy_next = sy3_reg * sy3_reg;
        f_next = 66'(tc3_reg) * signed'(66'({1'b0, time_step_reg}));
        gx_next = CORD_W'(gp5_reg >>> 30);
        hy_next = CORD_W'(hp5_reg >>> 30);
        dx_next = D_W'(dxp6_reg >>> 30);
        dy_next = D_W'(dyp6_reg >>> 30);
        sumx = SUM_W'(x6_reg) - SUM_W'(dx_next);
        sumy = SUM_W'(y6_reg) + SUM_W'(dy_next);
        nx_next = sat_cw(sumx);
        ny_next = sat_cw(sumy);
    end

endmodule
`default_nettype wire
